// ----- design/c8_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c8_pkg
// Shared types and constants for the CHIP-8 core.
// ----------------------------------------------------------------------------
package c8_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] address;
        logic [7:0]  write_data;
        logic [15:0] keys;
        logic [7:0]  rand_value;
    } c8_in_t;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [15:0] fetched_opcode;
        logic [63:0] row_pixels;
        logic        sound_active;
        logic        waiting_key;
    } c8_out_t;

    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_RUN     = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;
    localparam logic [1:0] MODE_RESTART = 2'd3;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_FONT  = 1'b1;

    // datapath commands
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_MEMWR     = 4'd1;  // host byte write
    localparam logic [3:0] CMD_RDROW     = 4'd2;
    localparam logic [3:0] CMD_RESTART   = 4'd3;
    localparam logic [3:0] CMD_FETCH_HI  = 4'd4;  // issue read pc
    localparam logic [3:0] CMD_FETCH_LO  = 4'd5;  // latch hi, read pc+1
    localparam logic [3:0] CMD_DECODE    = 4'd6;  // latch lo, pc += 2
    localparam logic [3:0] CMD_EXEC      = 4'd7;  // single step instructions
    localparam logic [3:0] CMD_CLS       = 4'd8;  // clear one row (step)
    localparam logic [3:0] CMD_SPR_RD    = 4'd9;  // read sprite byte (step)
    localparam logic [3:0] CMD_SPR_DRAW  = 4'd10; // draw one pixel (step)
    localparam logic [3:0] CMD_BCD       = 4'd11; // write one digit (step)
    localparam logic [3:0] CMD_STORE     = 4'd12; // write Vstep
    localparam logic [3:0] CMD_LOAD_RD   = 4'd13; // read I+step
    localparam logic [3:0] CMD_LOAD_WR   = 4'd14; // latch into Vstep-1
    localparam logic [3:0] CMD_FINISH    = 4'd15; // timers, result

    typedef struct packed {
        logic [3:0] cmd;
        logic [4:0] step;
        logic [2:0] col;
    } c8_ctl_t;

    typedef struct packed {
        logic [15:0] opcode;
    } c8_sts_t;

endpackage : c8_pkg
`default_nettype wire

// ----- design/chip8_cpu_core_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_cpu_core_unit
// CHIP-8 interpreter core: host memory load, instruction step, screen read.
// ----------------------------------------------------------------------------
// Memory write, row read and restart go straight to the result; an instruction
//   passes fetch, decode, execute and finish, plus loops for 00E0, Dxyn, Fx33,
//   Fx55 and Fx65 (one memory port, one pixel a cycle).
// Throughput: next transaction accepted in the cycle its result is taken.
// Reset: registers, timers, screen cleared; pc 512; memory and stack undefined.
module chip8_cpu_core_unit
    import c8_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire c8_in_t      in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output c8_out_t          out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);

    logic [11:0] start_reg, font_reg;
    c8_ctl_t     ctl;
    c8_sts_t     sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 12'd512;
            font_reg  <= 12'd80;
        end
        else if (cfg_valid)
        begin
            if (cfg_index[0] == CFG_START)
                start_reg <= cfg_data;
            else
                font_reg <= cfg_data;
        end
    end

    c8_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_mode   (in_data.mode),
        .sts       (sts),
        .ctl       (ctl),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    c8_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .item          (in_data),
        .restart_pc    (start_reg),
        .font_base     (font_reg),
        .sts           (sts),
        .result        (out_data)
    );

endmodule : chip8_cpu_core_unit
`default_nettype wire

// ----- design/c8_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c8_datapath
// Memory, registers, stack, timers and screen of the CHIP-8 core.
// ----------------------------------------------------------------------------
module c8_datapath
    import c8_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire c8_ctl_t ctl,
    input  wire c8_in_t  item,
    input  wire logic [11:0] restart_pc,
    input  wire logic [11:0] font_base,
    output c8_sts_t      sts,
    output c8_out_t      result
);

    logic [7:0]  mem [4096];
    logic [7:0]  mem_rdata_reg;
    logic [11:0] mem_raddr;
    logic        mem_we;
    logic [11:0] mem_waddr;
    logic [7:0]  mem_wdata;

    logic [11:0] stk [16];

    logic [7:0]  v_reg [16];
    logic [15:0] idx_reg, idx_next;
    logic [11:0] pc_reg, pc_next;
    logic [3:0]  sp_reg, sp_next;
    logic [7:0]  dt_reg, dt_next, st_reg, st_next;
    logic [15:0] op_reg, op_next;
    logic [63:0] scr_reg [32];
    logic [7:0]  spr_reg;
    logic [63:0] row_reg, row_next;
    logic        wait_reg, wait_next;
    logic [15:0] keys_reg;
    logic [7:0]  rnd_reg;
    logic [10:0] dxy_reg;

    logic        v_we;
    logic [3:0]  v_wa;
    logic [7:0]  v_wd;
    logic        vf_we;
    logic [7:0]  vf_wd;

    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy;
    logic [11:0] nnn;
    logic [8:0]  sum9;
    logic [7:0]  hund, tens, ones;
    logic [10:0] pix;
    logic [15:0] vx_times5;
    logic [3:0]  key_num;
    logic        key_found;
    logic        down;

    assign x   = op_reg[11:8];
    assign y   = op_reg[7:4];
    assign n   = op_reg[3:0];
    assign kk  = op_reg[7:0];
    assign nnn = op_reg[11:0];
    assign vx  = v_reg[x];
    assign vy  = v_reg[y];
    assign sum9 = {1'b0, vx} + {1'b0, vy};
    assign vx_times5 = {6'd0, vx, 2'd0} + {8'd0, vx};
    assign down = keys_reg[vx[3:0]];

    // BCD: hundreds by compare, tens by x*205 >> 11 (exact below 100)
    always_comb
    begin
        logic [7:0]  r;
        logic [15:0] prod;
        r = vx;
        hund = 8'd0;
        if (r >= 8'd200)
        begin
            hund = 8'd2;
            r = r - 8'd200;
        end
        else if (r >= 8'd100)
        begin
            hund = 8'd1;
            r = r - 8'd100;
        end
        prod = {8'd0, r} * 16'd205;
        tens = {3'd0, prod[15:11]};
        ones = r - {tens[4:0], 3'd0} - {tens[6:0], 1'b0};
    end

    always_comb
    begin
        key_found = 1'b0;
        key_num   = 4'd0;
        for (int k = 15; k >= 0; k--)
        begin
            if (keys_reg[k])
            begin
                key_found = 1'b1;
                key_num   = 4'(k);
            end
        end
    end

    // pixel position: (yp+row)*64 + xp + col, modulo 2048
    assign pix = dxy_reg + {1'b0, ctl.step[3:0], 6'd0} + {8'd0, ctl.col};

    always_comb
    begin
        mem_raddr = pc_reg;
        case (ctl.cmd)
            CMD_FETCH_HI: mem_raddr = pc_reg;
            CMD_FETCH_LO: mem_raddr = pc_reg + 12'd1;
            CMD_SPR_RD:   mem_raddr = idx_reg[11:0] + {8'd0, ctl.step[3:0]};
            CMD_LOAD_RD:  mem_raddr = idx_reg[11:0] + {8'd0, ctl.step[3:0]};
            default:      mem_raddr = pc_reg;
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = item.address;
        mem_wdata = item.write_data;
        case (ctl.cmd)
            CMD_MEMWR:
            begin
                mem_we = 1'b1;
            end
            CMD_BCD:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[11:0] + {10'd0, ctl.step[1:0]};
                mem_wdata = (ctl.step[1:0] == 2'd0) ? hund :
                            (ctl.step[1:0] == 2'd1) ? tens : ones;
            end
            CMD_STORE:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[11:0] + {8'd0, ctl.step[3:0]};
                mem_wdata = v_reg[ctl.step[3:0]];
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        idx_next  = idx_reg;
        pc_next   = pc_reg;
        sp_next   = sp_reg;
        dt_next   = dt_reg;
        st_next   = st_reg;
        op_next   = op_reg;
        row_next  = row_reg;
        wait_next = wait_reg;
        v_we  = 1'b0;
        v_wa  = x;
        v_wd  = vx;
        vf_we = 1'b0;
        vf_wd = 8'd0;
        case (ctl.cmd)
            CMD_MEMWR:
            begin
                row_next  = 64'd0;
                wait_next = 1'b0;
            end
            CMD_RDROW:
            begin
                row_next  = scr_reg[item.address[4:0]];
                wait_next = 1'b0;
            end
            CMD_RESTART:
            begin
                pc_next   = restart_pc;
                row_next  = 64'd0;
                wait_next = 1'b0;
            end
            CMD_FETCH_LO:
            begin
                op_next[15:8] = mem_rdata_reg;
                row_next      = 64'd0;
                wait_next     = 1'b0;
            end
            CMD_DECODE:
            begin
                op_next[7:0] = mem_rdata_reg;
                pc_next      = pc_reg + 12'd2;
            end
            CMD_EXEC:
            begin
                case (op_reg[15:12])
                    4'h0:
                    begin
                        if (op_reg == 16'h00EE)
                        begin
                            sp_next = sp_reg - 4'd1;
                            pc_next = stk[sp_reg - 4'd1];
                        end
                    end
                    4'h1: pc_next = nnn;
                    4'h2:
                    begin
                        sp_next = sp_reg + 4'd1;
                        pc_next = nnn;
                    end
                    4'h3: if (vx == kk) pc_next = pc_reg + 12'd2;
                    4'h4: if (vx != kk) pc_next = pc_reg + 12'd2;
                    4'h5: if (vx == vy) pc_next = pc_reg + 12'd2;
                    4'h6:
                    begin
                        v_we = 1'b1;
                        v_wd = kk;
                    end
                    4'h7:
                    begin
                        v_we = 1'b1;
                        v_wd = vx + kk;
                    end
                    4'h8:
                    begin
                        case (n)
                            4'h0: begin v_we = 1'b1; v_wd = vy; end
                            4'h1: begin v_we = 1'b1; v_wd = vx | vy; end
                            4'h2: begin v_we = 1'b1; v_wd = vx & vy; end
                            4'h3: begin v_we = 1'b1; v_wd = vx ^ vy; end
                            4'h4:
                            begin
                                v_we = 1'b1; v_wd = sum9[7:0];
                                vf_we = 1'b1; vf_wd = {7'd0, sum9[8]};
                            end
                            4'h5:
                            begin
                                v_we = 1'b1; v_wd = vx - vy;
                                vf_we = 1'b1; vf_wd = {7'd0, vx > vy};
                            end
                            4'h6:
                            begin
                                v_we = 1'b1; v_wd = {1'b0, vx[7:1]};
                                vf_we = 1'b1; vf_wd = {7'd0, vx[0]};
                            end
                            4'h7:
                            begin
                                v_we = 1'b1; v_wd = vy - vx;
                                vf_we = 1'b1; vf_wd = {7'd0, vy > vx};
                            end
                            4'hE:
                            begin
                                v_we = 1'b1; v_wd = {vx[6:0], 1'b0};
                                vf_we = 1'b1; vf_wd = {7'd0, vx[7]};
                            end
                            default: v_we = 1'b0;
                        endcase
                    end
                    4'h9: if (vx != vy) pc_next = pc_reg + 12'd2;
                    4'hA: idx_next = {4'd0, nnn};
                    4'hB: pc_next = {4'd0, v_reg[0]} + nnn;
                    4'hC:
                    begin
                        v_we = 1'b1;
                        v_wd = kk & rnd_reg;
                    end
                    4'hD:
                    begin
                        vf_we = 1'b1;
                        vf_wd = 8'd0;
                    end
                    4'hE:
                    begin
                        if ((kk == 8'h9E && down) || (kk == 8'hA1 && !down))
                            pc_next = pc_reg + 12'd2;
                    end
                    default:
                    begin
                        case (kk)
                            8'h07: begin v_we = 1'b1; v_wd = dt_reg; end
                            8'h0A:
                            begin
                                if (key_found)
                                begin
                                    v_we = 1'b1;
                                    v_wd = {4'd0, key_num};
                                end
                                else
                                begin
                                    pc_next   = pc_reg - 12'd2;
                                    wait_next = 1'b1;
                                end
                            end
                            8'h15: dt_next = vx;
                            8'h18: st_next = vx;
                            8'h1E: idx_next = idx_reg + {8'd0, vx};
                            8'h29: idx_next = {4'd0, font_base} + vx_times5;
                            default: idx_next = idx_reg;
                        endcase
                    end
                endcase
            end
            CMD_SPR_DRAW:
            begin
                if (spr_reg[3'd7 - ctl.col] && scr_reg[pix[10:6]][6'd63 - pix[5:0]])
                begin
                    vf_we = 1'b1;
                    vf_wd = 8'd1;
                end
            end
            CMD_LOAD_WR:
            begin
                v_we = 1'b1;
                v_wa = ctl.step[3:0] - 4'd1;
                v_wd = mem_rdata_reg;
            end
            CMD_FINISH:
            begin
                if (dt_reg != 8'd0)
                    dt_next = dt_reg - 8'd1;
                if (st_reg != 8'd0)
                    st_next = st_reg - 8'd1;
            end
            default: pc_next = pc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cmd == CMD_EXEC && op_reg[15:12] == 4'h2)
            stk[sp_reg] <= pc_reg;
        if (ctl.cmd == CMD_SPR_RD || ctl.cmd == CMD_LOAD_RD)
            spr_reg <= mem_rdata_reg;
        if (ctl.cmd == CMD_SPR_DRAW && ctl.col == 3'd0)
            spr_reg <= mem_rdata_reg;
        // input fields used after the transaction is accepted
        if (ctl.cmd == CMD_FETCH_HI)
        begin
            keys_reg <= item.keys;
            rnd_reg  <= item.rand_value;
        end
        // sprite origin taken before VF is cleared or set by the draw
        if (ctl.cmd == CMD_EXEC)
            dxy_reg <= {vy[4:0], vx[5:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 16'd0;
            pc_reg   <= 12'd512;
            sp_reg   <= 4'd0;
            dt_reg   <= 8'd0;
            st_reg   <= 8'd0;
            op_reg   <= 16'd0;
            row_reg  <= 64'd0;
            wait_reg <= 1'b0;
            for (int k = 0; k < 16; k++)
                v_reg[k] <= 8'd0;
            for (int k = 0; k < 32; k++)
                scr_reg[k] <= 64'd0;
        end
        else
        begin
            idx_reg  <= idx_next;
            pc_reg   <= pc_next;
            sp_reg   <= sp_next;
            dt_reg   <= dt_next;
            st_reg   <= st_next;
            op_reg   <= op_next;
            row_reg  <= row_next;
            wait_reg <= wait_next;
            if (vf_we)
                v_reg[15] <= vf_wd;
            if (v_we)
                v_reg[v_wa] <= v_wd;
            if (ctl.cmd == CMD_CLS)
                scr_reg[ctl.step] <= 64'd0;
            if (ctl.cmd == CMD_SPR_DRAW && spr_reg[3'd7 - ctl.col])
                scr_reg[pix[10:6]][6'd63 - pix[5:0]] <=
                    ~scr_reg[pix[10:6]][6'd63 - pix[5:0]];
        end
    end

    assign sts.opcode = op_reg;

    assign result.program_counter = pc_reg;
    assign result.fetched_opcode  = op_reg;
    assign result.row_pixels      = row_reg;
    assign result.sound_active    = (st_reg != 8'd0);
    assign result.waiting_key     = wait_reg;

endmodule : c8_datapath
`default_nettype wire

// ----- design/c8_control.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c8_control
// Sequencer: walks each run transaction through fetch, execute and its loops.
// ----------------------------------------------------------------------------
module c8_control
    import c8_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire logic [1:0] in_mode,
    input  wire c8_sts_t sts,
    output c8_ctl_t      ctl,
    output logic         out_valid,
    input  wire logic    out_stall
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FLO    = 4'd1;
    localparam logic [3:0] S_DEC    = 4'd2;
    localparam logic [3:0] S_EXEC   = 4'd3;
    localparam logic [3:0] S_CLS    = 4'd4;
    localparam logic [3:0] S_SPRRD  = 4'd5;
    localparam logic [3:0] S_SPRWT  = 4'd6;
    localparam logic [3:0] S_DRAW   = 4'd7;
    localparam logic [3:0] S_BCD    = 4'd8;
    localparam logic [3:0] S_STORE  = 4'd9;
    localparam logic [3:0] S_LDRD   = 4'd10;
    localparam logic [3:0] S_LDWR   = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [2:0] col_reg, col_next;
    logic       accept;
    logic [15:0] op;

    assign op        = sts.opcode;
    assign out_valid = (state_reg == S_OUT);
    assign in_stall  = !(state_reg == S_IDLE || (state_reg == S_OUT && !out_stall));
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        col_next   = col_reg;
        ctl.cmd    = CMD_NONE;
        ctl.step   = step_reg;
        ctl.col    = col_reg;
        if (state_reg == S_OUT && !out_stall)
            state_next = S_IDLE;
        case (state_reg)
            S_IDLE, S_OUT:
            begin
                if (accept)
                begin
                    step_next = 5'd0;
                    col_next  = 3'd0;
                    case (in_mode)
                        MODE_WRITE:   begin ctl.cmd = CMD_MEMWR;   state_next = S_OUT; end
                        MODE_READ:    begin ctl.cmd = CMD_RDROW;   state_next = S_OUT; end
                        MODE_RESTART: begin ctl.cmd = CMD_RESTART; state_next = S_OUT; end
                        default:      begin ctl.cmd = CMD_FETCH_HI; state_next = S_FLO; end
                    endcase
                end
            end
            S_FLO:
            begin
                ctl.cmd = CMD_FETCH_LO;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                ctl.cmd = CMD_DECODE;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ctl.cmd = CMD_EXEC;
                state_next = S_FIN;
                if (op == 16'h00E0)
                    state_next = S_CLS;
                else if (op[15:12] == 4'hD && op[3:0] != 4'd0)
                    state_next = S_SPRRD;
                else if (op[15:12] == 4'hF && op[7:0] == 8'h33)
                    state_next = S_BCD;
                else if (op[15:12] == 4'hF && op[7:0] == 8'h55)
                    state_next = S_STORE;
                else if (op[15:12] == 4'hF && op[7:0] == 8'h65)
                    state_next = S_LDRD;
            end
            S_CLS:
            begin
                ctl.cmd = CMD_CLS;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31)
                    state_next = S_FIN;
            end
            S_SPRRD:
            begin
                // memory read issued, data next cycle
                ctl.cmd = CMD_SPR_RD;
                state_next = S_SPRWT;
            end
            S_SPRWT:
            begin
                ctl.cmd = CMD_SPR_RD;
                state_next = S_DRAW;
            end
            S_DRAW:
            begin
                ctl.cmd = CMD_SPR_DRAW;
                col_next = col_reg + 3'd1;
                if (col_reg == 3'd7)
                begin
                    step_next = step_reg + 5'd1;
                    if (step_reg[3:0] + 4'd1 == op[3:0])
                        state_next = S_FIN;
                    else
                        state_next = S_SPRRD;
                end
            end
            S_BCD:
            begin
                ctl.cmd = CMD_BCD;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd2)
                    state_next = S_FIN;
            end
            S_STORE:
            begin
                ctl.cmd = CMD_STORE;
                step_next = step_reg + 5'd1;
                if (step_reg[3:0] == op[11:8])
                    state_next = S_FIN;
            end
            S_LDRD:
            begin
                ctl.cmd = CMD_LOAD_RD;
                step_next = step_reg + 5'd1;
                state_next = S_LDWR;
            end
            S_LDWR:
            begin
                ctl.cmd = CMD_LOAD_WR;
                if (step_reg[3:0] - 4'd1 == op[11:8])
                    state_next = S_FIN;
                else
                    state_next = S_LDRD;
            end
            S_FIN:
            begin
                ctl.cmd = CMD_FINISH;
                state_next = S_OUT;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 5'd0;
            col_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            col_reg   <= col_next;
        end
    end

endmodule : c8_control
`default_nettype wire

// ----- test/tb_chip8_cpu_core_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_chip8_cpu_core_unit
// Loads programs into the CHIP-8 core, steps instructions, reads screen rows
// and restarts, predicting every result with a behavioral model of the core.
// ----------------------------------------------------------------------------
module tb_chip8_cpu_core_unit;
    import c8_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    c8_in_t      in_data;
    logic        out_valid;
    logic        out_stall;
    c8_out_t     out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [11:0] cfg_data;

    chip8_cpu_core_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [7:0]  mem [4096];
    bit          mem_known [4096];
    logic [7:0]  vreg [16];
    logic [15:0] idx_reg;
    logic [11:0] pc;
    logic [11:0] call_stack [16];
    logic [3:0]  sp;
    logic [7:0]  dtimer;
    logic [7:0]  stimer;
    logic [63:0] frame [32];
    logic [15:0] last_op;
    logic [11:0] start_addr;
    logic [11:0] font_addr;

    c8_out_t     expected_q [$];
    int          mismatches;
    int          mismatch_reports;
    int          idle_cycles;
    bit          no_idle;
    bit          hold_output;
    int          hold_count;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void mem_write(input logic [11:0] a, input logic [7:0] d);
        mem[a] = d;
        mem_known[a] = 1'b1;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < 16; i++)
            vreg[i] = '0;
        for (int r = 0; r < 32; r++)
            frame[r] = '0;
        for (int a = 0; a < 4096; a++)
            mem_known[a] = 1'b0;
        idx_reg    = '0;
        start_addr = 12'd512;
        font_addr  = 12'd80;
        pc         = 12'd512;
        sp         = '0;
        dtimer     = '0;
        stimer     = '0;
        last_op    = '0;
    endfunction

    function automatic void draw(input logic [7:0] vx, input logic [7:0] vy,
                                 input logic [3:0] height);
        int          xp;
        int          yp;
        int          pix;
        logic [7:0]  bits;
        logic [63:0] m;
        xp = vx % 64;
        yp = vy % 32;
        vreg[15] = 8'd0;
        for (int row = 0; row < height; row++)
        begin
            bits = mem[12'(idx_reg + row)];
            for (int col = 0; col < 8; col++)
            begin
                if (bits[7 - col])
                begin
                    pix = ((yp + row) * 64 + xp + col) % 2048;
                    m = 64'd1 << (63 - pix % 64);
                    if ((frame[pix / 64] & m) != 0)
                        vreg[15] = 8'd1;
                    frame[pix / 64] ^= m;
                end
            end
        end
    endfunction

    // one instruction cycle; returns 1 when Fx0A found no key
    function automatic bit step_instruction(input logic [15:0] keys, input logic [7:0] rnd);
        logic [15:0] op;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  kk;
        logic [11:0] nnn;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [8:0]  sum;
        bit          waiting;
        bit          down;
        int          k;
        op = {mem[pc], mem[pc + 12'd1]};
        last_op = op;
        pc = pc + 12'd2;
        x = op[11:8];
        y = op[7:4];
        kk = op[7:0];
        nnn = op[11:0];
        a = vreg[x];
        b = vreg[y];
        waiting = 1'b0;
        case (op[15:12])
            4'h0:
            begin
                if (op == 16'h00E0)
                begin
                    for (int r = 0; r < 32; r++)
                        frame[r] = '0;
                end
                else if (op == 16'h00EE)
                begin
                    sp = sp - 4'd1;
                    pc = call_stack[sp];
                end
            end
            4'h1: pc = nnn;
            4'h2:
            begin
                call_stack[sp] = pc;
                sp = sp + 4'd1;
                pc = nnn;
            end
            4'h3: if (a == kk) pc = pc + 12'd2;
            4'h4: if (a != kk) pc = pc + 12'd2;
            4'h5: if (a == b) pc = pc + 12'd2;
            4'h6: vreg[x] = kk;
            4'h7: vreg[x] = a + kk;
            4'h8:
            begin
                case (op[3:0])
                    4'h0: vreg[x] = b;
                    4'h1: vreg[x] = a | b;
                    4'h2: vreg[x] = a & b;
                    4'h3: vreg[x] = a ^ b;
                    4'h4:
                    begin
                        sum = {1'b0, a} + {1'b0, b};
                        vreg[15] = {7'd0, sum[8]};
                        vreg[x] = sum[7:0];
                    end
                    4'h5:
                    begin
                        vreg[15] = {7'd0, a > b};
                        vreg[x] = a - b;
                    end
                    4'h6:
                    begin
                        vreg[15] = {7'd0, a[0]};
                        vreg[x] = a >> 1;
                    end
                    4'h7:
                    begin
                        vreg[15] = {7'd0, b > a};
                        vreg[x] = b - a;
                    end
                    4'hE:
                    begin
                        vreg[15] = {7'd0, a[7]};
                        vreg[x] = a << 1;
                    end
                    default: ;
                endcase
            end
            4'h9: if (a != b) pc = pc + 12'd2;
            4'hA: idx_reg = {4'd0, nnn};
            4'hB: pc = 12'(vreg[0] + nnn);
            4'hC: vreg[x] = kk & rnd;
            4'hD: draw(a, b, op[3:0]);
            4'hE:
            begin
                down = keys[a[3:0]];
                if (kk == 8'h9E && down)
                    pc = pc + 12'd2;
                else if (kk == 8'hA1 && !down)
                    pc = pc + 12'd2;
            end
            default:
            begin
                case (kk)
                    8'h07: vreg[x] = dtimer;
                    8'h0A:
                    begin
                        k = 16;
                        for (int i = 15; i >= 0; i--)
                            if (keys[i])
                                k = i;
                        if (k < 16)
                            vreg[x] = 8'(k);
                        else
                        begin
                            pc = pc - 12'd2;
                            waiting = 1'b1;
                        end
                    end
                    8'h15: dtimer = a;
                    8'h18: stimer = a;
                    8'h1E: idx_reg = idx_reg + {8'd0, a};
                    8'h29: idx_reg = 16'({4'd0, font_addr} + 16'd5 * a);
                    8'h33:
                    begin
                        mem_write(12'(idx_reg + 2), 8'(a % 10));
                        mem_write(12'(idx_reg + 1), 8'((a / 10) % 10));
                        mem_write(12'(idx_reg), 8'(a / 100));
                    end
                    8'h55:
                        for (int i = 0; i <= x; i++)
                            mem_write(12'(idx_reg + i), vreg[i]);
                    8'h65:
                        for (int i = 0; i <= x; i++)
                            vreg[i] = mem[12'(idx_reg + i)];
                    default: ;
                endcase
            end
        endcase
        if (dtimer != 0)
            dtimer = dtimer - 8'd1;
        if (stimer != 0)
            stimer = stimer - 8'd1;
        return waiting;
    endfunction

    function automatic c8_out_t predict_core(input c8_in_t item);
        c8_out_t res;
        bit      waiting;
        waiting = 1'b0;
        res.row_pixels = '0;
        case (item.mode)
            MODE_WRITE:   mem_write(item.address, item.write_data);
            MODE_RUN:     waiting = step_instruction(item.keys, item.rand_value);
            MODE_READ:    res.row_pixels = frame[item.address[4:0]];
            default:      pc = start_addr;
        endcase
        res.program_counter = pc;
        res.fetched_opcode  = last_op;
        res.sound_active    = (stimer != 0);
        res.waiting_key     = waiting;
        return res;
    endfunction

    function automatic bit take_idle();
        return !no_idle && ($urandom_range(99) < 20);
    endfunction

    // valid stays up after acceptance until the next call idles or drain() takes it down
    task automatic send_item(input c8_in_t item);
        while (take_idle())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        expected_q.push_back(predict_core(item));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_config(input logic [0:0] index, input logic [11:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_START)
            start_addr = value;
        else
            font_addr = value;
    endtask

    task automatic poke(input logic [11:0] a, input logic [7:0] d);
        c8_in_t item;
        item = '{mode: MODE_WRITE, address: a, write_data: d, keys: 16'h0, rand_value: 8'h0};
        send_item(item);
    endtask

    task automatic run_op(input logic [15:0] keys, input logic [7:0] rnd);
        c8_in_t item;
        item = '{mode: MODE_RUN, address: 12'($urandom), write_data: 8'($urandom),
                 keys: keys, rand_value: rnd};
        send_item(item);
    endtask

    task automatic simple_op(input c8_in_t base, input logic [1:0] mode);
        c8_in_t item;
        item = base;
        item.mode = mode;
        send_item(item);
    endtask

    // make every byte an instruction may read already written
    task automatic prepare_reads(input logic [15:0] op);
        logic [11:0] base;
        int          count;
        base = 12'(idx_reg);
        count = 0;
        if (op[15:12] == 4'hD)
            count = op[3:0];
        else if (op[15:12] == 4'hF && op[7:0] == 8'h65)
            count = op[11:8] + 1;
        for (int i = 0; i < count; i++)
            if (!mem_known[base + 12'(i)])
                poke(base + 12'(i), 8'($urandom));
    endtask

    // place an instruction at the current pc and execute it
    task automatic exec_op(input logic [15:0] op, input logic [15:0] keys,
                           input logic [7:0] rnd);
        logic [11:0] at;
        at = pc;
        poke(at, op[15:8]);
        poke(at + 12'd1, op[7:0]);
        prepare_reads(op);
        run_op(keys, rnd);
    endtask

    function automatic logic [15:0] random_opcode();
        logic [15:0] op;
        logic [3:0]  top;
        op = 16'($urandom);
        top = op[15:12];
        // keep the stack away from never-written entries
        if (top == 4'h0 && $urandom_range(3) == 0)
            op = 16'h00E0;
        else if (top == 4'h0 && $urandom_range(1) == 0 && sp != 0)
            op = 16'h00EE;
        else if (top == 4'h0 || (top == 4'hF && op[7:0] == 8'h0A && $urandom_range(1) == 0))
            op = {4'h8, op[11:4], 4'($urandom_range(15))};
        if (op[15:12] == 4'hD)
            op[3:0] = 4'($urandom_range(4));
        if (op[15:12] == 4'hE)
            op[7:0] = $urandom_range(1) ? 8'h9E : 8'hA1;
        if (op[15:12] == 4'hF && $urandom_range(4) != 0)
        begin
            case ($urandom_range(8))
                0: op[7:0] = 8'h07;
                1: op[7:0] = 8'h0A;
                2: op[7:0] = 8'h15;
                3: op[7:0] = 8'h18;
                4: op[7:0] = 8'h1E;
                5: op[7:0] = 8'h29;
                6: op[7:0] = 8'h33;
                7: op[7:0] = 8'h55;
                default: op[7:0] = 8'h65;
            endcase
        end
        return op;
    endfunction

    task automatic random_program_step();
        logic [15:0] op;
        logic [15:0] keys;
        op = random_opcode();
        if (!mem_known[pc] || !mem_known[pc + 12'd1] || $urandom_range(3) == 0)
        begin
            poke(pc, op[15:8]);
            poke(pc + 12'd1, op[7:0]);
        end
        op = {mem[pc], mem[pc + 12'd1]};
        if (op[15:12] == 4'h0 && op[11:0] == 12'h0EE && sp == 0)
        begin
            op = 16'h00E0;
            poke(pc, op[15:8]);
            poke(pc + 12'd1, op[7:0]);
        end
        prepare_reads(op);
        keys = $urandom_range(3) == 0 ? 16'h0 : 16'($urandom) & 16'($urandom);
        run_op(keys, 8'($urandom));
    endtask

    task automatic test_directed();
        c8_in_t item;
        item = '{mode: MODE_READ, address: 12'hFFF, write_data: 8'hFF,
                 keys: 16'hFFFF, rand_value: 8'hFF};
        simple_op(item, MODE_READ);
        simple_op(item, MODE_RESTART);
        exec_op(16'h60FF, 16'h0000, 8'h00);
        exec_op(16'h61FF, 16'h0000, 8'h00);
        exec_op(16'h8014, 16'h0000, 8'h00);
        exec_op(16'h801E, 16'h0000, 8'h00);
        exec_op(16'h8F16, 16'h0000, 8'h00);
        exec_op(16'hCFFF, 16'hFFFF, 8'hA5);
        exec_op(16'hF00A, 16'h0000, 8'h00);
        exec_op(16'hF00A, 16'h8000, 8'h00);
        exec_op(16'hAFFE, 16'h0000, 8'h00);
        exec_op(16'hF155, 16'h0000, 8'h00);
        exec_op(16'hD017, 16'h0000, 8'h00);
        item.mode = MODE_READ;
        item.address = 12'h01F;
        simple_op(item, MODE_READ);
        exec_op(16'hF018, 16'h0000, 8'h00);
        exec_op(16'hF029, 16'h0000, 8'h00);
        exec_op(16'h00E0, 16'h0000, 8'h00);
    endtask

    task automatic test_config();
        write_config(CFG_START, 12'hFFE);
        write_config(CFG_FONT, 12'hFFF);
        simple_op('0, MODE_RESTART);
        exec_op(16'h6A33, 16'h0000, 8'h00);
        exec_op(16'hFA29, 16'h0000, 8'h00);
        exec_op(16'hFA33, 16'h0000, 8'h00);
        write_config(CFG_START, 12'h000);
        write_config(CFG_FONT, 12'h000);
        simple_op('0, MODE_RESTART);
        exec_op(16'hF029, 16'h0000, 8'h00);
        write_config(CFG_START, 12'h300);
        write_config(CFG_FONT, 12'h050);
        simple_op('0, MODE_RESTART);
    endtask

    task automatic test_random(input int count);
        c8_in_t item;
        for (int n = 0; n < count; n++)
        begin
            no_idle = (n >= count / 3 && n < count / 2);
            item = c8_in_t'({$urandom, $urandom});
            case ($urandom_range(19))
                0: simple_op(item, MODE_READ);
                1: if (mem_known[start_addr] && mem_known[start_addr + 12'd1])
                       simple_op(item, MODE_RESTART);
                2: simple_op(item, MODE_WRITE);
                default: random_program_step();
            endcase
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_count  = 300;
        hold_output = 1'b1;
        for (int n = 0; n < 20; n++)
            random_program_step();
        drain();
        for (int n = 0; n < 20; n++)
            random_program_step();
    endtask

    always @(posedge clk)
    begin
        if (hold_output)
        begin
            out_stall <= 1'b1;
            if (hold_count > 0)
                hold_count <= hold_count - 1;
            else
                hold_output <= 1'b0;
        end
        else
            out_stall <= take_idle();
    end

    always @(posedge clk)
    begin
        c8_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatch_reports < 10)
                begin
                    mismatch_reports++;
                    $display("unexpected result transaction: %p", out_data);
                end
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data.program_counter !== want.program_counter
                    || out_data.fetched_opcode !== want.fetched_opcode
                    || out_data.row_pixels !== want.row_pixels
                    || out_data.sound_active !== want.sound_active
                    || out_data.waiting_key !== want.waiting_key)
                begin
                    mismatches++;
                    if (mismatch_reports < 10)
                    begin
                        mismatch_reports++;
                        $display("result mismatch: expected %p actual %p", want, out_data);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready) || hold_output)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        no_idle     = 1'b0;
        hold_output = 1'b0;
        hold_count  = 0;
        mismatches  = 0;
        mismatch_reports = 0;
        idle_cycles = 0;
        reset_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config();
        test_backpressure();
        test_random(620);
        drain();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule : tb_chip8_cpu_core_unit
`default_nettype wire
